/* hdl/ocp_pkg.sv */
// Shared package for the orbit camera position core.
// Holds field widths, request and register codes, and the sequencer microprogram.
// No dependencies.
`default_nettype none

package ocp_pkg;

	// Field widths
	localparam int REQ_W  = 3;
	localparam int AMT_W  = 16;
	localparam int POS_W  = 24;
	localparam int RATE_W = 16;
	localparam int SPOL_W = 15;
	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_TILT_UP    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_TILT_DOWN  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_TURN_LEFT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_TURN_RIGHT = 3'd3;
	localparam logic [REQ_W-1:0] REQ_ZOOM_IN    = 3'd4;
	localparam logic [REQ_W-1:0] REQ_ZOOM_OUT   = 3'd5;
	localparam logic [REQ_W-1:0] REQ_NONE       = 3'd6;

	// Register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_TURN_RATE      = 3'd0;
	localparam logic [2:0] REG_ZOOM_RATE      = 3'd1;
	localparam logic [2:0] REG_START_AZIMUTH  = 3'd2;
	localparam logic [2:0] REG_START_POLAR    = 3'd3;
	localparam logic [2:0] REG_START_DISTANCE = 3'd4;

	// Register reset values
	localparam logic [RATE_W-1:0]       RST_TURN_RATE = 16'd256;
	localparam logic [RATE_W-1:0]       RST_ZOOM_RATE = 16'd256;
	localparam logic [15:0]             RST_AZIMUTH   = 16'd0;
	localparam logic [SPOL_W-1:0]       RST_POLAR     = 15'd16384;
	localparam logic signed [POS_W-1:0] RST_DISTANCE  = 24'sd20480;

	// Distance and coordinate range
	localparam logic signed [POS_W-1:0] DIST_MAX = 24'sh7FFFFF;
	localparam logic signed [POS_W-1:0] DIST_MIN = 24'sh800000;

	// Half pi in Q30, and the Q16 unit
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] UNIT_Q16    = 64'd65536;

	// Sequencer step addresses
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_UPDATE = 4'd1;
	localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd9;

	// Multiplier operand selects
	typedef enum logic [1:0] {MA_RATE, MA_SV, MA_SPQ, MA_ACC} ma_sel_t;
	typedef enum logic [1:0] {MB_AMT, MB_RAD, MB_SV, MB_TMP} mb_sel_t;
	// Sine lookup angle selects
	typedef enum logic [1:0] {LK_POLAR, LK_POLAR_Q, LK_AZ, LK_AZ_Q} lk_sel_t;
	// Jump conditions
	typedef enum logic [1:0] {C_NEVER, C_ALWAYS, C_NO_EVT, C_OUT_BUSY} cond_t;

	// One control word
	typedef struct packed {
		ma_sel_t           ma;
		mb_sel_t           mb;
		logic              mul;
		logic              upd;
		logic              lk;
		lk_sel_t           lsel;
		logic              ld_sp;
		logic              ld_tmp;
		logic              ld_y;
		logic              ld_z;
		logic              ld_out;
		cond_t             cond;
		logic              fin;
		logic [STEP_W-1:0] tgt;
	} ucw_t;

	localparam ucw_t UW_RESTART = '{ma: MA_RATE, mb: MB_AMT, mul: 1'b0, upd: 1'b0, lk: 1'b0,
		lsel: LK_POLAR, ld_sp: 1'b0, ld_tmp: 1'b0, ld_y: 1'b0, ld_z: 1'b0, ld_out: 1'b0,
		cond: C_ALWAYS, fin: 1'b0, tgt: STEP_IDLE};

	// Microprogram: scale, update, four sine lookups, five multiplies, emit
	localparam ucw_t UCODE [0:(1<<STEP_W)-1] = '{
		// idle: wait for a beat, form rate * amount
		0: '{ma: MA_RATE, mb: MB_AMT, mul: 1'b1, upd: 1'b0, lk: 1'b0, lsel: LK_POLAR,
			ld_sp: 1'b0, ld_tmp: 1'b0, ld_y: 1'b0, ld_z: 1'b0, ld_out: 1'b0,
			cond: C_NO_EVT, fin: 1'b0, tgt: STEP_IDLE},
		// apply the event to the angles or the distance
		1: '{ma: MA_RATE, mb: MB_AMT, mul: 1'b0, upd: 1'b1, lk: 1'b0, lsel: LK_POLAR,
			ld_sp: 1'b0, ld_tmp: 1'b0, ld_y: 1'b0, ld_z: 1'b0, ld_out: 1'b0,
			cond: C_NEVER, fin: 1'b0, tgt: STEP_IDLE},
		// look up sin(polar)
		2: '{ma: MA_RATE, mb: MB_AMT, mul: 1'b0, upd: 1'b0, lk: 1'b1, lsel: LK_POLAR,
			ld_sp: 1'b0, ld_tmp: 1'b0, ld_y: 1'b0, ld_z: 1'b0, ld_out: 1'b0,
			cond: C_NEVER, fin: 1'b0, tgt: STEP_IDLE},
		// look up cos(polar), hold sin(polar)
		3: '{ma: MA_RATE, mb: MB_AMT, mul: 1'b0, upd: 1'b0, lk: 1'b1, lsel: LK_POLAR_Q,
			ld_sp: 1'b1, ld_tmp: 1'b0, ld_y: 1'b0, ld_z: 1'b0, ld_out: 1'b0,
			cond: C_NEVER, fin: 1'b0, tgt: STEP_IDLE},
		// look up sin(az), cos(polar) * d
		4: '{ma: MA_SV, mb: MB_RAD, mul: 1'b1, upd: 1'b0, lk: 1'b1, lsel: LK_AZ,
			ld_sp: 1'b0, ld_tmp: 1'b0, ld_y: 1'b0, ld_z: 1'b0, ld_out: 1'b0,
			cond: C_NEVER, fin: 1'b0, tgt: STEP_IDLE},
		// look up cos(az), round y, sin(polar) * sin(az)
		5: '{ma: MA_SPQ, mb: MB_SV, mul: 1'b1, upd: 1'b0, lk: 1'b1, lsel: LK_AZ_Q,
			ld_sp: 1'b0, ld_tmp: 1'b0, ld_y: 1'b1, ld_z: 1'b0, ld_out: 1'b0,
			cond: C_NEVER, fin: 1'b0, tgt: STEP_IDLE},
		// hold cos(az), product * d
		6: '{ma: MA_ACC, mb: MB_RAD, mul: 1'b1, upd: 1'b0, lk: 1'b0, lsel: LK_POLAR,
			ld_sp: 1'b0, ld_tmp: 1'b1, ld_y: 1'b0, ld_z: 1'b0, ld_out: 1'b0,
			cond: C_NEVER, fin: 1'b0, tgt: STEP_IDLE},
		// round z, sin(polar) * cos(az)
		7: '{ma: MA_SPQ, mb: MB_TMP, mul: 1'b1, upd: 1'b0, lk: 1'b0, lsel: LK_POLAR,
			ld_sp: 1'b0, ld_tmp: 1'b0, ld_y: 1'b0, ld_z: 1'b1, ld_out: 1'b0,
			cond: C_NEVER, fin: 1'b0, tgt: STEP_IDLE},
		// product * d
		8: '{ma: MA_ACC, mb: MB_RAD, mul: 1'b1, upd: 1'b0, lk: 1'b0, lsel: LK_POLAR,
			ld_sp: 1'b0, ld_tmp: 1'b0, ld_y: 1'b0, ld_z: 1'b0, ld_out: 1'b0,
			cond: C_NEVER, fin: 1'b0, tgt: STEP_IDLE},
		// round x and emit; stay while the output register is still full
		9: '{ma: MA_RATE, mb: MB_AMT, mul: 1'b0, upd: 1'b0, lk: 1'b0, lsel: LK_POLAR,
			ld_sp: 1'b0, ld_tmp: 1'b0, ld_y: 1'b0, ld_z: 1'b0, ld_out: 1'b1,
			cond: C_OUT_BUSY, fin: 1'b1, tgt: STEP_EMIT},
		default: UW_RESTART
	};

endpackage

`default_nettype wire

/* hdl/ocp_ifs.sv */
// Valid/ready channel interfaces for the orbit camera position core.
// ocp_evt_if carries input events, ocp_pos_if carries camera positions.
// Depends on ocp_pkg for field widths.
`default_nettype none

interface ocp_evt_if;
	logic                        valid;
	logic                        ready;
	logic [ocp_pkg::REQ_W-1:0]   req_type;
	logic [ocp_pkg::AMT_W-1:0]   amount;

	modport source (output valid, req_type, amount, input ready);
	modport sink   (input valid, req_type, amount, output ready);
endinterface

interface ocp_pos_if;
	logic                               valid;
	logic                               ready;
	logic signed [ocp_pkg::POS_W-1:0]   pos_x;
	logic signed [ocp_pkg::POS_W-1:0]   pos_y;
	logic signed [ocp_pkg::POS_W-1:0]   pos_z;
	logic                               distance_saturated;

	modport source (output valid, pos_x, pos_y, pos_z, distance_saturated, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, distance_saturated, output ready);
endinterface

`default_nettype wire

/* hdl/orbit_camera_position_core.sv */
// Orbit camera position core: microcoded sequencer with one shared multiplier.
// Depends on ocp_pkg (codes, microprogram) and ocp_ifs (channel interfaces).
//
// Usage:
//   evt carries one event beat (req_type, amount). Tilt, turn or zoom is applied
//   to the stored azimuth, polar angle and distance, and exactly one pos beat
//   (pos_x, pos_y, pos_z, distance_saturated) follows for every event.
//   The APB port writes rates and start values; writing a start register also
//   loads the matching state at once. Write configuration only while idle.
// Timing:
//   evt.ready is high while the sequencer sits in its idle step, so a new event
//   is taken only after the previous one has run through the ten-step
//   microprogram: the rate multiply, the state update, four lookups into the
//   single sine ROM port, five passes through the shared 36x24 multiplier,
//   and last the emit step that loads the result into the output register.
//   A result waiting in the output register does not block the next event;
//   only the emit step holds until the register is free.
// Reset:
//   arst_n clears the sequencer and the output valid flag and loads registers and
//   state with their reset values.
`default_nettype none

module orbit_camera_position_core #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int ANGLE_BITS       = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ocp_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [ocp_pkg::CFG_DW-1:0]  pwdata,
	output logic      [ocp_pkg::CFG_DW-1:0]  prdata,
	output logic                             pready,
	ocp_evt_if.sink                          evt,
	ocp_pos_if.source                        pos
);

	localparam int IW   = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PW   = ANGLE_BITS - 2 + IW;
	localparam int WMAX = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
	localparam int TW   = WMAX + 2;
	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
	localparam logic [63:0] POLAR_MARGIN =
		((64'd1 << ANGLE_BITS) * 64'd15915494) / 64'd10000000000;
	localparam logic signed [TW-1:0] POLAR_LO = TW'(POLAR_MARGIN);
	localparam logic signed [TW-1:0] POLAR_HI =
		TW'((64'd1 << (ANGLE_BITS - 1)) - POLAR_MARGIN);

	// Quarter-wave sine entry in Q16 from a truncating Q30 series
	function automatic logic [16:0] sin_val(input int unsigned i);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic signed [63:0] v;
		x    = (64'(i) * ocp_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - $signed(term);
		if (sum < 0) begin
			sum = 0;
		end
		v = (sum + 64'sd8192) >>> 14;
		if (v > $signed(ocp_pkg::UNIT_Q16)) begin
			v = $signed(ocp_pkg::UNIT_Q16);
		end
		return 17'(v);
	endfunction

	// Round half up by 2^sh and saturate to 24 bits
	function automatic logic signed [23:0] rnd_sat(input logic signed [59:0] v,
			input int unsigned sh);
		logic signed [60:0] t;
		t = (61'(v) + (61'sd1 <<< (sh - 1))) >>> sh;
		if (t > 61'(ocp_pkg::DIST_MAX)) begin
			return ocp_pkg::DIST_MAX;
		end else if (t < 61'(ocp_pkg::DIST_MIN)) begin
			return ocp_pkg::DIST_MIN;
		end
		return $signed(t[23:0]);
	endfunction

	// Configuration registers
	logic [ocp_pkg::RATE_W-1:0]       turn_rate_q;
	logic [ocp_pkg::RATE_W-1:0]       zoom_rate_q;
	logic [15:0]                      start_az_q;
	logic [ocp_pkg::SPOL_W-1:0]       start_pol_q;
	logic signed [ocp_pkg::POS_W-1:0] start_dist_q;

	// Camera state
	logic [ANGLE_BITS-1:0]            az_q;
	logic [ANGLE_BITS-2:0]            polar_q;
	logic signed [ocp_pkg::POS_W-1:0] radius_q;

	// Sequencer and datapath
	logic [ocp_pkg::STEP_W-1:0]       step_q;
	logic [ocp_pkg::STEP_W-1:0]       step_nx;
	ocp_pkg::ucw_t                    uc;
	logic                             jump;
	logic [ocp_pkg::REQ_W-1:0]        kind_q;
	logic signed [59:0]               acc_q;
	logic signed [35:0]               opa;
	logic signed [23:0]               opb;
	logic signed [59:0]               prod;
	logic [16:0]                      rom_q;
	logic                             neg_q;
	logic signed [17:0]               sv;
	logic signed [17:0]               sp_q;
	logic signed [17:0]               tmp_q;
	logic signed [23:0]               y_q;
	logic signed [23:0]               z_q;
	logic                             sat_q;

	// Output register
	logic                             out_vld_q;
	logic signed [23:0]               out_x_q;
	logic signed [23:0]               out_y_q;
	logic signed [23:0]               out_z_q;
	logic                             out_sat_q;
	logic                             out_busy;
	logic                             out_load;

	logic                             cfg_wr;
	logic                             evt_fire;
	logic [ocp_pkg::RATE_W-1:0]       rate_sel;

	// Update results
	logic [15:0]                      astep;
	logic [ANGLE_BITS-1:0]            az_nx;
	logic [ANGLE_BITS-2:0]            polar_nx;
	logic signed [ocp_pkg::POS_W-1:0] radius_nx;
	logic                             sat_nx;
	logic signed [TW-1:0]             pt;
	logic signed [25:0]               rt;

	// Sine ROM and its address
	logic [16:0]                      sin_rom [0:SINE_TABLE_DEPTH];
	logic [ANGLE_BITS-1:0]            lk_ang;
	logic [PW-1:0]                    lk_prod;
	logic [IW-1:0]                    lk_idx;
	logic [IW-1:0]                    lk_addr;

	for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_sin
		assign sin_rom[g] = sin_val(g);
	end

	// APB write strobe and read mux
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[4:2])
			ocp_pkg::REG_TURN_RATE:      prdata = 32'(turn_rate_q);
			ocp_pkg::REG_ZOOM_RATE:      prdata = 32'(zoom_rate_q);
			ocp_pkg::REG_START_AZIMUTH:  prdata = 32'(start_az_q);
			ocp_pkg::REG_START_POLAR:    prdata = 32'(start_pol_q);
			ocp_pkg::REG_START_DISTANCE: prdata = 32'(start_dist_q);
			default:                     prdata = '0;
		endcase
	end

	// Fetch the control word and pick the next step
	assign uc       = ocp_pkg::UCODE[step_q];
	assign evt.ready = (step_q == ocp_pkg::STEP_IDLE);
	assign evt_fire = evt.valid && evt.ready;
	assign out_busy = out_vld_q && !pos.ready;
	assign out_load = uc.ld_out && !out_busy;

	always_comb begin
		case (uc.cond)
			ocp_pkg::C_NEVER:    jump = 1'b0;
			ocp_pkg::C_ALWAYS:   jump = 1'b1;
			ocp_pkg::C_NO_EVT:   jump = !evt.valid;
			ocp_pkg::C_OUT_BUSY: jump = out_busy;
			default:             jump = 1'b0;
		endcase
		if (jump) begin
			step_nx = uc.tgt;
		end else if (uc.fin) begin
			step_nx = ocp_pkg::STEP_IDLE;
		end else begin
			step_nx = step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ocp_pkg::STEP_IDLE;
		end else begin
			step_q <= step_nx;
		end
	end

	// Select multiplier operands
	assign rate_sel = (evt.req_type == ocp_pkg::REQ_ZOOM_IN ||
		evt.req_type == ocp_pkg::REQ_ZOOM_OUT) ? zoom_rate_q : turn_rate_q;
	assign sv = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

	always_comb begin
		case (uc.ma)
			ocp_pkg::MA_RATE: opa = $signed(36'(rate_sel));
			ocp_pkg::MA_SV:   opa = 36'(sv);
			ocp_pkg::MA_SPQ:  opa = 36'(sp_q);
			ocp_pkg::MA_ACC:  opa = acc_q[35:0];
			default:          opa = '0;
		endcase
		case (uc.mb)
			ocp_pkg::MB_AMT: opb = $signed(24'(evt.amount));
			ocp_pkg::MB_RAD: opb = radius_q;
			ocp_pkg::MB_SV:  opb = 24'(sv);
			ocp_pkg::MB_TMP: opb = 24'(tmp_q);
			default:         opb = '0;
		endcase
	end

	assign prod = opa * opb;

	// Compute the state update for the latched event
	assign astep = acc_q[31:16];

	always_comb begin
		az_nx     = az_q;
		polar_nx  = polar_q;
		radius_nx = radius_q;
		sat_nx    = 1'b0;
		pt        = $signed(TW'(polar_q));
		rt        = 26'(radius_q);
		case (kind_q)
			ocp_pkg::REQ_TILT_UP: begin
				pt = $signed(TW'(polar_q)) - $signed(TW'(astep));
				if (pt < POLAR_LO) begin
					pt = POLAR_LO;
				end
				polar_nx = (ANGLE_BITS - 1)'(pt);
			end
			ocp_pkg::REQ_TILT_DOWN: begin
				pt = $signed(TW'(polar_q)) + $signed(TW'(astep));
				if (pt > POLAR_HI) begin
					pt = POLAR_HI;
				end
				polar_nx = (ANGLE_BITS - 1)'(pt);
			end
			ocp_pkg::REQ_TURN_LEFT: begin
				az_nx = ANGLE_BITS'(WMAX'(az_q) + WMAX'(astep));
			end
			ocp_pkg::REQ_TURN_RIGHT: begin
				az_nx = ANGLE_BITS'(WMAX'(az_q) - WMAX'(astep));
			end
			ocp_pkg::REQ_ZOOM_IN, ocp_pkg::REQ_ZOOM_OUT: begin
				if (kind_q == ocp_pkg::REQ_ZOOM_IN) begin
					rt = $signed(26'(radius_q)) - $signed(26'(astep));
				end else begin
					rt = $signed(26'(radius_q)) + $signed(26'(astep));
				end
				if (rt > 26'(ocp_pkg::DIST_MAX)) begin
					radius_nx = ocp_pkg::DIST_MAX;
					sat_nx    = 1'b1;
				end else if (rt < 26'(ocp_pkg::DIST_MIN)) begin
					radius_nx = ocp_pkg::DIST_MIN;
					sat_nx    = 1'b1;
				end else begin
					radius_nx = rt[23:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Hold configuration and camera state; start writes load the state at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_rate_q  <= ocp_pkg::RST_TURN_RATE;
			zoom_rate_q  <= ocp_pkg::RST_ZOOM_RATE;
			start_az_q   <= ocp_pkg::RST_AZIMUTH;
			start_pol_q  <= ocp_pkg::RST_POLAR;
			start_dist_q <= ocp_pkg::RST_DISTANCE;
			az_q         <= ANGLE_BITS'(ocp_pkg::RST_AZIMUTH);
			polar_q      <= (ANGLE_BITS - 1)'(ocp_pkg::RST_POLAR);
			radius_q     <= ocp_pkg::RST_DISTANCE;
			sat_q        <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				ocp_pkg::REG_TURN_RATE: begin
					turn_rate_q <= pwdata[15:0];
				end
				ocp_pkg::REG_ZOOM_RATE: begin
					zoom_rate_q <= pwdata[15:0];
				end
				ocp_pkg::REG_START_AZIMUTH: begin
					start_az_q <= pwdata[15:0];
					az_q       <= ANGLE_BITS'(pwdata[15:0]);
				end
				ocp_pkg::REG_START_POLAR: begin
					start_pol_q <= pwdata[14:0];
					polar_q     <= (ANGLE_BITS - 1)'(pwdata[14:0]);
				end
				ocp_pkg::REG_START_DISTANCE: begin
					start_dist_q <= $signed(pwdata[23:0]);
					radius_q     <= $signed(pwdata[23:0]);
				end
				default: begin
				end
			endcase
		end else if (uc.upd) begin
			az_q     <= az_nx;
			polar_q  <= polar_nx;
			radius_q <= radius_nx;
			sat_q    <= sat_nx;
		end
	end

	// Fold the lookup angle into a quarter-wave ROM address
	always_comb begin
		case (uc.lsel)
			ocp_pkg::LK_POLAR:   lk_ang = ANGLE_BITS'(polar_q);
			ocp_pkg::LK_POLAR_Q: lk_ang = ANGLE_BITS'(polar_q) + QUARTER;
			ocp_pkg::LK_AZ:      lk_ang = az_q;
			ocp_pkg::LK_AZ_Q:    lk_ang = az_q + QUARTER;
			default:             lk_ang = az_q;
		endcase
	end

	assign lk_prod = PW'(lk_ang[ANGLE_BITS-3:0]) * PW'(SINE_TABLE_DEPTH);
	assign lk_idx  = IW'(lk_prod >> (ANGLE_BITS - 2));
	assign lk_addr = lk_ang[ANGLE_BITS-2] ? IW'(SINE_TABLE_DEPTH) - lk_idx : lk_idx;

	// Datapath registers: event kind, ROM read, accumulator, operand holds, rounded results, output fields
	always_ff @(posedge clk) begin
		if (evt_fire) begin
			kind_q <= evt.req_type;
		end
		if (uc.lk) begin
			rom_q <= sin_rom[lk_addr];
			neg_q <= lk_ang[ANGLE_BITS-1];
		end
		if (uc.mul) begin
			acc_q <= prod;
		end
		if (uc.ld_sp) begin
			sp_q <= sv;
		end
		if (uc.ld_tmp) begin
			tmp_q <= sv;
		end
		if (uc.ld_y) begin
			y_q <= rnd_sat(acc_q, 16);
		end
		if (uc.ld_z) begin
			z_q <= rnd_sat(acc_q, 32);
		end
		if (out_load) begin
			out_x_q   <= rnd_sat(acc_q, 32);
			out_y_q   <= y_q;
			out_z_q   <= z_q;
			out_sat_q <= sat_q;
		end
	end

	// Output beat valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (pos.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign pos.valid              = out_vld_q;
	assign pos.pos_x              = out_x_q;
	assign pos.pos_y              = out_y_q;
	assign pos.pos_z              = out_z_q;
	assign pos.distance_saturated = out_sat_q;

	// An accepted beat starts the update step next
	a_accept_to_update: assert property (@(posedge clk) disable iff (!arst_n)
		evt_fire |=> step_q == ocp_pkg::STEP_UPDATE)
		else $error("sequencer did not advance to the update step");

	// A full, stalled output register holds the emit step
	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == ocp_pkg::STEP_EMIT && out_vld_q && !pos.ready
		|=> step_q == ocp_pkg::STEP_EMIT)
		else $error("emit step left while the output register was full");

	// Tilt up never leaves the polar angle below the margin
	a_tilt_up_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		uc.upd && !cfg_wr && kind_q == ocp_pkg::REQ_TILT_UP
		|=> $signed(TW'(polar_q)) >= POLAR_LO)
		else $error("polar angle fell below the lower limit");

	// Saturation is reported only for zoom events
	a_sat_only_zoom: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && sat_q |-> kind_q == ocp_pkg::REQ_ZOOM_IN || kind_q == ocp_pkg::REQ_ZOOM_OUT)
		else $error("distance saturation flagged for a non-zoom event");

endmodule

`default_nettype wire

/* bench/camera_position_checker.sv */
// Position checker for the orbit camera position core: predicts every position beat
// from the event and APB traffic it observes, and compares the results field by field.
// Depends on ocp_pkg and the ocp_evt_if / ocp_pos_if interfaces.
`default_nettype none

module camera_position_checker #(
	parameter int SINE_DEPTH = 1024,
	parameter int ANGLE_W    = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic                        pready,
	input  wire logic [ocp_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [ocp_pkg::CFG_DW-1:0]  pwdata,
	ocp_evt_if                               evt,
	ocp_pos_if                               pos,
	output int                               fail_count,
	output int                               pending_count,
	output int                               checked_count,
	output int                               clip_count
);

	typedef longint unsigned u64_t;

	typedef struct {
		logic signed [ocp_pkg::POS_W-1:0] x;
		logic signed [ocp_pkg::POS_W-1:0] y;
		logic signed [ocp_pkg::POS_W-1:0] z;
		logic                             sat;
	} cam_pos_t;

	localparam u64_t   ANG_MASK    = (u64_t'(1) << ANGLE_W) - 1;
	localparam u64_t   ANG_QUARTER = u64_t'(1) << (ANGLE_W - 2);
	localparam longint ANG_HALF    = longint'(1) << (ANGLE_W - 1);
	// 0.01 rad expressed in binary-angle units
	localparam longint POL_MARGIN  = ((longint'(1) << ANGLE_W) * 64'sd15915494) /
		64'sd10000000000;
	localparam longint POL_LO      = POL_MARGIN;
	localparam longint POL_HI      = ANG_HALF - POL_MARGIN;

	longint   quarter_sine [0:SINE_DEPTH];
	cam_pos_t expected_positions [$];

	// predicted registers and camera state
	logic [ocp_pkg::RATE_W-1:0] rate_turn;
	logic [ocp_pkg::RATE_W-1:0] rate_zoom;
	logic [15:0]                cam_az;
	longint                     cam_pol;
	longint                     cam_rad;

	int mismatches = 0;
	int checked    = 0;
	int clips      = 0;

	// Build the quarter-wave sine table from a truncated Q30 Taylor series
	initial begin
		u64_t   ang;
		u64_t   sq;
		u64_t   term;
		longint acc;
		longint val;
		for (int i = 0; i <= SINE_DEPTH; i++) begin
			ang  = (u64_t'(i) * ocp_pkg::HALF_PI_Q30) / u64_t'(SINE_DEPTH);
			sq   = (ang * ang) >> 30;
			term = ang;
			acc  = longint'(ang);
			for (int k = 1; k <= 7; k++) begin
				term = (term * sq) >> 30;
				term = term / u64_t'((2 * k) * (2 * k + 1));
				if (k % 2 == 1)
					acc -= longint'(term);
				else
					acc += longint'(term);
			end
			if (acc < 0)
				acc = 0;
			val = (acc + 8192) >>> 14;
			if (val > longint'(ocp_pkg::UNIT_Q16))
				val = longint'(ocp_pkg::UNIT_Q16);
			quarter_sine[i] = val;
		end
	end

	// Table sine of a binary angle: fold by quadrant, no interpolation
	function automatic longint table_sine(input u64_t ang);
		u64_t   a;
		u64_t   idx;
		longint v;
		a   = ang & ANG_MASK;
		idx = ((a & (ANG_QUARTER - 1)) * u64_t'(SINE_DEPTH)) / ANG_QUARTER;
		if (idx > u64_t'(SINE_DEPTH))
			idx = u64_t'(SINE_DEPTH);
		v = a[ANGLE_W-2] ? quarter_sine[SINE_DEPTH - int'(idx)] : quarter_sine[idx];
		return a[ANGLE_W-1] ? -v : v;
	endfunction

	function automatic longint round_half_up(input longint v, input int sh);
		longint half;
		half = longint'(1) << (sh - 1);
		if (v >= 0)
			return (v + half) >>> sh;
		return -((-v + half - 1) >>> sh);
	endfunction

	function automatic logic signed [ocp_pkg::POS_W-1:0] clip_coord(input longint v);
		if (v > ocp_pkg::DIST_MAX)
			return ocp_pkg::DIST_MAX;
		if (v < ocp_pkg::DIST_MIN)
			return ocp_pkg::DIST_MIN;
		return v[ocp_pkg::POS_W-1:0];
	endfunction

	// Apply one event to the camera and work out the position it emits
	function automatic cam_pos_t step_camera(input logic [ocp_pkg::REQ_W-1:0] req,
		input logic [ocp_pkg::AMT_W-1:0] amt);
		longint   astep;
		longint   zstep;
		longint   sp;
		longint   cp;
		longint   sa;
		longint   ca;
		cam_pos_t p;
		astep = (longint'(rate_turn) * longint'(amt)) >>> 16;
		zstep = (longint'(rate_zoom) * longint'(amt)) >>> 16;
		p.sat = 1'b0;
		case (req)
			ocp_pkg::REQ_TILT_UP: begin
				cam_pol -= astep;
				if (cam_pol < POL_LO)
					cam_pol = POL_LO;
			end
			ocp_pkg::REQ_TILT_DOWN: begin
				cam_pol += astep;
				if (cam_pol > POL_HI)
					cam_pol = POL_HI;
			end
			ocp_pkg::REQ_TURN_LEFT:  cam_az = cam_az + astep[15:0];
			ocp_pkg::REQ_TURN_RIGHT: cam_az = cam_az - astep[15:0];
			ocp_pkg::REQ_ZOOM_IN, ocp_pkg::REQ_ZOOM_OUT: begin
				cam_rad += (req == ocp_pkg::REQ_ZOOM_IN) ? -zstep : zstep;
				if (cam_rad > ocp_pkg::DIST_MAX) begin
					cam_rad = ocp_pkg::DIST_MAX;
					p.sat   = 1'b1;
				end
				if (cam_rad < ocp_pkg::DIST_MIN) begin
					cam_rad = ocp_pkg::DIST_MIN;
					p.sat   = 1'b1;
				end
			end
			default: ;
		endcase
		sp = table_sine(u64_t'(cam_pol));
		cp = table_sine(u64_t'(cam_pol) + ANG_QUARTER);
		sa = table_sine(u64_t'(cam_az));
		ca = table_sine(u64_t'(cam_az) + ANG_QUARTER);
		p.x = clip_coord(round_half_up(sp * ca * cam_rad, 32));
		p.y = clip_coord(round_half_up(cp * cam_rad, 16));
		p.z = clip_coord(round_half_up(sp * sa * cam_rad, 32));
		return p;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] position %0d: %s", $time, checked, msg);
	endtask

	// Track register writes and events, compare each position beat
	always @(posedge clk or negedge arst_n) begin
		cam_pos_t want;
		if (!arst_n) begin
			rate_turn = ocp_pkg::RST_TURN_RATE;
			rate_zoom = ocp_pkg::RST_ZOOM_RATE;
			cam_az    = ocp_pkg::RST_AZIMUTH;
			cam_pol   = longint'(ocp_pkg::RST_POLAR);
			cam_rad   = ocp_pkg::RST_DISTANCE;
			expected_positions.delete();
			pending_count <= 0;
		end else begin
			// compare first: a beat taken now belongs to an earlier event
			if (pos.valid && pos.ready) begin
				if (expected_positions.size() == 0) begin
					report_mismatch("position beat with no event waiting");
				end else begin
					want = expected_positions.pop_front();
					if (pos.pos_x !== want.x)
						report_mismatch($sformatf("pos_x got %0d expected %0d", pos.pos_x, want.x));
					if (pos.pos_y !== want.y)
						report_mismatch($sformatf("pos_y got %0d expected %0d", pos.pos_y, want.y));
					if (pos.pos_z !== want.z)
						report_mismatch($sformatf("pos_z got %0d expected %0d", pos.pos_z, want.z));
					if (pos.distance_saturated !== want.sat)
						report_mismatch($sformatf("distance_saturated got %b expected %b",
							pos.distance_saturated, want.sat));
					checked++;
				end
			end
			// start registers load their state entry at once
			if (psel && penable && pwrite && pready) begin
				case (paddr[ocp_pkg::CFG_AW-1:2])
					ocp_pkg::REG_TURN_RATE:
						rate_turn = pwdata[ocp_pkg::RATE_W-1:0];
					ocp_pkg::REG_ZOOM_RATE:
						rate_zoom = pwdata[ocp_pkg::RATE_W-1:0];
					ocp_pkg::REG_START_AZIMUTH:
						cam_az = pwdata[15:0];
					ocp_pkg::REG_START_POLAR:
						cam_pol = longint'(pwdata[ocp_pkg::SPOL_W-1:0]);
					ocp_pkg::REG_START_DISTANCE:
						cam_rad = longint'(signed'(pwdata[ocp_pkg::POS_W-1:0]));
					default: ;
				endcase
			end
			if (evt.valid && evt.ready) begin
				want = step_camera(evt.req_type, evt.amount);
				if (want.sat)
					clips++;
				expected_positions.push_back(want);
			end
			pending_count <= expected_positions.size();
		end
		fail_count    <= mismatches;
		checked_count <= checked;
		clip_count    <= clips;
	end

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Top of the orbit camera position bench: clock, reset, APB writes, event stimulus
// and a stalling position receiver; camera_position_checker predicts and compares.
// Depends on ocp_pkg, ocp_ifs, orbit_camera_position_core and camera_position_checker.
`default_nettype none

module testbench;

	localparam logic [ocp_pkg::REQ_W-1:0] REQ_RESERVED = 3'd7;
	localparam logic [2:0]                REG_UNUSED   = 3'd6;
	localparam int                        PHASES       = 6;
	localparam int                        PHASE_EVENTS = 150;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [ocp_pkg::CFG_AW-1:0] paddr;
	logic [ocp_pkg::CFG_DW-1:0] pwdata;
	logic [ocp_pkg::CFG_DW-1:0] prdata;
	logic                       pready;

	int fail_count;
	int pending_count;
	int checked_count;
	int clip_count;
	int events_sent = 0;

	ocp_evt_if evt_ch ();
	ocp_pos_if pos_ch ();

	orbit_camera_position_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.evt     (evt_ch),
		.pos     (pos_ch)
	);

	camera_position_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.evt           (evt_ch),
		.pos           (pos_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count),
		.clip_count    (clip_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Give up if the run hangs
	initial begin
		#5000000;
		$display("timeout with %0d positions still expected", pending_count);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Offer one event beat after an idle gap; leave valid high on return
	task automatic send_event(input logic [ocp_pkg::REQ_W-1:0] req,
		input logic [ocp_pkg::AMT_W-1:0] amt, input int gap);
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_ch.valid    <= 1'b1;
		evt_ch.req_type <= req;
		evt_ch.amount   <= amt;
		do @(posedge clk); while (!evt_ch.ready);
		events_sent <= events_sent + 1;
	endtask

	// Drop valid and wait until every position has come back
	task automatic drain_positions();
		evt_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (12) @(posedge clk);
	endtask

	// Setup cycle, then access cycle until pready
	task automatic write_reg(input logic [2:0] idx, input logic [ocp_pkg::CFG_DW-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Position receiver: random stalls, clean stretches, one long hold-off
	initial begin
		bit held = 1'b0;
		int len;
		int pick;
		pos_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!held && events_sent >= 400) begin
				held = 1'b1;
				pos_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				pick = $urandom_range(99);
				if (pick < 10) begin
					pos_ch.ready <= 1'b1;
					len = $urandom_range(50, 200);
				end else if (pick < 55) begin
					pos_ch.ready <= 1'b1;
					len = $urandom_range(1, 6);
				end else if (pick < 95) begin
					pos_ch.ready <= 1'b0;
					len = $urandom_range(1, 4);
				end else begin
					pos_ch.ready <= 1'b0;
					len = $urandom_range(20, 60);
				end
				repeat (len) @(posedge clk);
			end
		end
	end

	// Stimulus: reset, directed events, then randomized phases of settings
	initial begin
		logic [ocp_pkg::REQ_W-1:0]  kind;
		logic [ocp_pkg::AMT_W-1:0]  amt;
		logic [ocp_pkg::RATE_W-1:0] t_rate;
		logic [ocp_pkg::RATE_W-1:0] z_rate;
		logic [15:0]                az0;
		logic [ocp_pkg::SPOL_W-1:0] pol0;
		logic [ocp_pkg::POS_W-1:0]  dist0;
		logic [31:0]                noise;
		int                         gap;
		int                         burst_left;
		int                         pick;

		arst_n          <= 1'b0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		evt_ch.valid    <= 1'b0;
		evt_ch.req_type <= ocp_pkg::REQ_NONE;
		evt_ch.amount   <= '0;
		burst_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: every request code, small steps
		send_event(ocp_pkg::REQ_NONE, 16'h0000, 0);
		send_event(REQ_RESERVED, 16'hFFFF, 1);
		send_event(ocp_pkg::REQ_TILT_UP, 16'hFFFF, 0);
		send_event(ocp_pkg::REQ_TILT_DOWN, 16'h1234, 2);
		send_event(ocp_pkg::REQ_TURN_LEFT, 16'hFFFF, 0);
		send_event(ocp_pkg::REQ_TURN_RIGHT, 16'h0100, 0);
		send_event(ocp_pkg::REQ_ZOOM_IN, 16'hFFFF, 1);
		send_event(ocp_pkg::REQ_ZOOM_OUT, 16'h8000, 0);

		// full turn rate: clamp at both polar limits, wrap the azimuth
		drain_positions();
		write_reg(ocp_pkg::REG_TURN_RATE, 32'h0000_FFFF);
		send_event(ocp_pkg::REQ_TILT_UP, 16'hFFFF, 0);
		send_event(ocp_pkg::REQ_TILT_DOWN, 16'hFFFF, 0);
		send_event(ocp_pkg::REQ_TURN_RIGHT, 16'hFFFF, 1);
		send_event(ocp_pkg::REQ_TURN_LEFT, 16'hFFFF, 0);

		// zoom saturation at both ends of the distance range
		drain_positions();
		write_reg(ocp_pkg::REG_ZOOM_RATE, 32'h0000_FFFF);
		write_reg(ocp_pkg::REG_START_DISTANCE, 32'h007F_FF00);
		send_event(ocp_pkg::REQ_ZOOM_OUT, 16'hFFFF, 0);
		send_event(ocp_pkg::REQ_ZOOM_IN, 16'hFFFF, 0);
		drain_positions();
		write_reg(ocp_pkg::REG_START_DISTANCE, 32'hFF80_0000);
		send_event(ocp_pkg::REQ_ZOOM_IN, 16'h0001, 0);
		send_event(ocp_pkg::REQ_ZOOM_IN, 16'hFFFF, 1);
		send_event(ocp_pkg::REQ_ZOOM_OUT, 16'hFFFF, 0);

		// polar start above the upper limit, kept until a tilt down
		drain_positions();
		write_reg(ocp_pkg::REG_START_POLAR, 32'hFFFF_FFFF);
		write_reg(ocp_pkg::REG_START_AZIMUTH, 32'hFFFF_FFFF);
		send_event(ocp_pkg::REQ_TILT_UP, 16'h0010, 0);
		send_event(ocp_pkg::REQ_TURN_LEFT, 16'h0000, 0);
		send_event(ocp_pkg::REQ_TILT_DOWN, 16'h0000, 0);

		// polar start below the lower limit, kept until a tilt up
		drain_positions();
		write_reg(ocp_pkg::REG_START_POLAR, 32'h0000_0000);
		write_reg(REG_UNUSED, 32'hDEAD_BEEF);
		send_event(ocp_pkg::REQ_TILT_DOWN, 16'h0040, 0);
		send_event(ocp_pkg::REQ_TILT_UP, 16'h0000, 0);

		for (int ph = 0; ph < PHASES; ph++) begin
			// pick a setting: the two first phases are the extremes
			if (ph == 0) begin
				t_rate = 16'hFFFF;
				z_rate = 16'hFFFF;
				az0    = 16'hFFFF;
				pol0   = 15'h7FFF;
				dist0  = 24'h7FFFFF;
			end else if (ph == 1) begin
				t_rate = 16'h0000;
				z_rate = 16'hFFFF;
				az0    = 16'h0000;
				pol0   = 15'h0000;
				dist0  = 24'h800000;
			end else begin
				case ($urandom_range(3))
					0:       t_rate = 16'h0000;
					1:       t_rate = 16'hFFFF;
					default: t_rate = 16'($urandom_range(0, 65535));
				endcase
				case ($urandom_range(3))
					0:       z_rate = 16'h0001;
					1:       z_rate = 16'hFFFF;
					default: z_rate = 16'($urandom_range(0, 65535));
				endcase
				az0 = 16'($urandom_range(0, 65535));
				case ($urandom_range(4))
					0:       pol0 = 15'd104;
					1:       pol0 = 15'd32664;
					default: pol0 = 15'($urandom_range(0, 32767));
				endcase
				case ($urandom_range(4))
					0:       dist0 = 24'h7FFFFF;
					1:       dist0 = 24'h800000;
					2:       dist0 = 24'($urandom_range(0, 40000));
					default: dist0 = 24'($urandom_range(0, 24'hFFFFFF));
				endcase
			end
			drain_positions();
			// unused upper data bits carry noise
			noise = $urandom();
			write_reg(ocp_pkg::REG_TURN_RATE, {noise[31:16], t_rate});
			write_reg(ocp_pkg::REG_ZOOM_RATE, {noise[15:0], z_rate});
			write_reg(ocp_pkg::REG_START_AZIMUTH, {noise[23:8], az0});
			write_reg(ocp_pkg::REG_START_POLAR, {noise[31:15], pol0});
			write_reg(ocp_pkg::REG_START_DISTANCE, {noise[7:0], dist0});

			for (int n = 0; n < PHASE_EVENTS; n++) begin
				kind = 3'($urandom_range(0, 7));
				pick = $urandom_range(9);
				if (pick == 0)
					amt = 16'h0000;
				else if (pick == 1)
					amt = 16'hFFFF;
				else if (pick < 5)
					amt = 16'($urandom_range(0, 1023));
				else
					amt = 16'($urandom_range(0, 65535));
				// mostly short gaps, some long, and bursts with none
				if (burst_left > 0) begin
					burst_left--;
					gap = 0;
				end else begin
					pick = $urandom_range(99);
					if (pick < 5) begin
						burst_left = $urandom_range(10, 40);
						gap = 0;
					end else if (pick < 55)
						gap = 0;
					else if (pick < 88)
						gap = $urandom_range(1, 3);
					else if (pick < 97)
						gap = $urandom_range(4, 12);
					else
						gap = $urandom_range(20, 60);
				end
				send_event(kind, amt, gap);
			end
		end

		// let the last positions come back, then the tail
		evt_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (30) @(posedge clk);

		$display("%0d events over directed cases and %0d register settings", events_sent, PHASES);
		$display("%0d positions compared, %0d of them with a clipped zoom",
			checked_count, clip_count);
		if (fail_count == 0 && pending_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
